[rtl/core/boce_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the open-circuit voltage estimator.
// No dependencies.
package boce_pkg;

  localparam int NumBits = 128;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_DIV,
    ST_ROUND,
    ST_SCALE,
    ST_OUT
  } boce_state_t;

  typedef enum logic [2:0] {
    REG_REF_TEMP   = 3'd0,
    REG_SERIES_RES = 3'd1,
    REG_SERIES_TC  = 3'd2,
    REG_RELAX_RES  = 3'd3,
    REG_RELAX_TC   = 3'd4,
    REG_TIME_CONST = 3'd5,
    REG_INTERVAL   = 3'd6
  } boce_reg_t;

  typedef struct packed {
    logic [15:0] reference_temp_ck;
    logic [29:0] series_res_uohm;
    logic [30:0] series_res_tempco;
    logic [29:0] relax_res_uohm;
    logic [30:0] relax_res_tempco;
    logic [19:0] time_constant_ms;
    logic [19:0] sample_interval_ms;
  } boce_cfg_t;

  // Shared multiplier operation request.
  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } boce_mul_req_t;

endpackage

[rtl/core/boce_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
interface boce_if #(parameter int Width = 48) (input logic clk);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/battery_open_circuit_voltage_estimator_unit.sv]
`timescale 1ns / 1ps
// Top level of the battery open-circuit voltage estimator.
// Depends on boce_pkg, boce_if, boce_mul and boce_div.
//
// Each input beat is one sample of current, terminal voltage and temperature.
// The unit keeps the doubled trapezoidal charge integral, the previous current
// and a first-order filter state (nV) that estimates the resistive drop. The
// result beat is built in these steps once the input beat is accepted: the
// setup states PREP and LOAD, three filter products on the shared multiplier
// (four 32x32 partial products each), a state that latches the sign, a
// bit-serial 128-bit division, a rounding state, a fourth product that
// divides the drop by 1000 through a reciprocal and an output state. The
// input is not ready while a sample is in work or while the result is held
// in the output register, so a new sample is taken only once the previous
// one is through and its result has left the output register. Configuration
// uses an APB-style port, 32-bit registers at 4*i.
module battery_open_circuit_voltage_estimator_unit import boce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  boce_if.sink        in_ch,
  boce_if.source      out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  boce_cfg_t cfg_r;
  boce_state_t st_r, st_nxt;
  boce_reg_t   reg_sel;

  logic signed [15:0]  cur_r, prev_r;
  logic [15:0]         volt_r;
  logic signed [16:0]  dt_r;
  logic signed [63:0]  charge_r;
  logic signed [47:0]  x_r;
  logic [31:0]         cnt_r;
  logic signed [63:0]  r0c_r, rinfc_r;
  logic signed [127:0] num_r;
  logic [31:0]         den_r;
  logic [20:0]         ts_r, tc_r;
  logic                neg_r;

  boce_mul_req_t       mreq;
  logic                mdone;
  logic signed [127:0] mprod;
  logic                dstart, ddone;
  logic [127:0]        dquo;
  logic [32:0]         drem;

  logic [31:0]         o_voc_r;
  logic signed [63:0]  o_chg_r;
  logic [31:0]         o_cnt_r;
  logic                o_valid_r;

  assign reg_sel    = boce_reg_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;

  // Register file write and read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reference_temp_ck  <= 16'd29815;
      cfg_r.series_res_uohm    <= '0;
      cfg_r.series_res_tempco  <= '0;
      cfg_r.relax_res_uohm     <= '0;
      cfg_r.relax_res_tempco   <= '0;
      cfg_r.time_constant_ms   <= 20'd1000;
      cfg_r.sample_interval_ms <= 20'd1000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_sel)
        REG_REF_TEMP:   cfg_r.reference_temp_ck  <= cfg_pwdata[15:0];
        REG_SERIES_RES: cfg_r.series_res_uohm    <= cfg_pwdata[29:0];
        REG_SERIES_TC:  cfg_r.series_res_tempco  <= cfg_pwdata[30:0];
        REG_RELAX_RES:  cfg_r.relax_res_uohm     <= cfg_pwdata[29:0];
        REG_RELAX_TC:   cfg_r.relax_res_tempco   <= cfg_pwdata[30:0];
        REG_TIME_CONST: cfg_r.time_constant_ms   <= cfg_pwdata[19:0];
        REG_INTERVAL:   cfg_r.sample_interval_ms <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REF_TEMP:   cfg_prdata = {16'd0, cfg_r.reference_temp_ck};
      REG_SERIES_RES: cfg_prdata = {2'd0, cfg_r.series_res_uohm};
      REG_SERIES_TC:  cfg_prdata = {1'b0, cfg_r.series_res_tempco};
      REG_RELAX_RES:  cfg_prdata = {2'd0, cfg_r.relax_res_uohm};
      REG_RELAX_TC:   cfg_prdata = {1'b0, cfg_r.relax_res_tempco};
      REG_TIME_CONST: cfg_prdata = {12'd0, cfg_r.time_constant_ms};
      REG_INTERVAL:   cfg_prdata = {12'd0, cfg_r.sample_interval_ms};
      default:        cfg_prdata = '0;
    endcase
  end

  boce_mul u_mul (.clk, .rst_n, .req(mreq), .done(mdone), .prod(mprod));
  boce_div u_div (.clk, .rst_n, .start(dstart), .num(num_r[127] ? 128'(-num_r) : num_r),
                  .den(den_r), .done(ddone), .quo(dquo), .rem(drem));

  assign in_ch.ready  = (st_r == ST_IDLE) && !o_valid_r;
  assign out_ch.valid = o_valid_r;
  assign out_ch.data  = {o_voc_r, o_chg_r, o_cnt_r};

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_ch.valid && in_ch.ready) st_nxt = ST_PREP;
      ST_PREP:  st_nxt = ST_LOAD;
      ST_LOAD:  st_nxt = ST_MUL_A;
      ST_MUL_A: if (mdone) st_nxt = ST_MUL_B;
      ST_MUL_B: if (mdone) st_nxt = ST_MUL_C;
      ST_MUL_C: if (mdone) st_nxt = ST_MUL_D;
      ST_MUL_D: st_nxt = ST_DIV;
      ST_DIV:   if (ddone) st_nxt = ST_ROUND;
      ST_ROUND: st_nxt = ST_SCALE;
      ST_SCALE: if (mdone) st_nxt = ST_OUT;
      ST_OUT:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Datapath terms.
  logic signed [63:0]  step;
  logic signed [64:0]  csum;
  logic [127:0]        qr;
  logic signed [47:0]  xn;
  logic [47:0]         qk;
  logic signed [49:0]  voc;
  logic signed [63:0]  chg;

  // Multiplier operands per phase; each request fires on phase entry. The
  // scale phase multiplies the rounded drop magnitude plus 500 by ceil(2^58/1000), which
  // gives the exact quotient by 1000 for any magnitude below 2^48.
  logic signed [63:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_nxt)
      ST_MUL_A: begin
        ma = $signed(64'(ts_r)) * (64'(cur_r) + 64'(prev_r));
        mb = rinfc_r;
      end
      ST_MUL_B: begin
        ma = $signed(64'({tc_r, 1'b0})) * (64'(cur_r) - 64'(prev_r));
        mb = r0c_r;
      end
      ST_MUL_C: begin
        ma = 64'(($signed({2'b0, tc_r, 1'b0}) - $signed({3'b0, ts_r})) * 64'sd100);
        mb = 64'(x_r);
      end
      ST_SCALE: begin
        ma = $signed(64'(qr[47:0]) + 64'd500);
        mb = 64'sd288230376151712;
      end
      default: ;
    endcase
  end
  assign mreq.start = (st_nxt != st_r) &&
                      (st_nxt == ST_MUL_A || st_nxt == ST_MUL_B || st_nxt == ST_MUL_C ||
                       st_nxt == ST_SCALE);
  assign mreq.a = ma;
  assign mreq.b = mb;
  assign dstart = (st_r == ST_MUL_D);

  always_comb begin
    step = $signed(64'(ts_r)) * (64'(cur_r) + 64'(prev_r));
    csum = 65'(charge_r) + 65'(step);
    qr   = dquo + 128'({drem, 1'b0} >= {1'b0, den_r});
    if (qr > 128'(neg_r ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF))
      qr = 128'(neg_r ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);
    xn   = neg_r ? -$signed(qr[47:0]) : $signed(qr[47:0]);
    qk   = mprod[105:58];
    voc  = $signed({34'd0, volt_r}) * 50'sd1000 + (x_r[47] ? -$signed({2'b0, qk})
                                                          : $signed({2'b0, qk}));
    chg  = charge_r >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      prev_r    <= '0;
      charge_r  <= '0;
      x_r       <= '0;
      cnt_r     <= '0;
      o_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) o_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          cur_r  <= $signed(in_ch.data[47:32]);
          volt_r <= in_ch.data[31:16];
          dt_r   <= $signed({1'b0, in_ch.data[15:0]}) -
                    $signed({1'b0, cfg_r.reference_temp_ck});
          ts_r   <= (cfg_r.sample_interval_ms == '0) ? 21'd1 : {1'b0, cfg_r.sample_interval_ms};
          tc_r   <= (cfg_r.time_constant_ms == '0) ? 21'd1 : {1'b0, cfg_r.time_constant_ms};
        end
        ST_PREP: begin
          r0c_r   <= 64'($signed({1'b0, cfg_r.series_res_uohm}) * 64'sd100) +
                     64'($signed(cfg_r.series_res_tempco)) * 64'(dt_r);
          rinfc_r <= 64'($signed({1'b0, cfg_r.series_res_uohm}) * 64'sd100) +
                     64'($signed(cfg_r.series_res_tempco)) * 64'(dt_r) +
                     64'($signed({1'b0, cfg_r.relax_res_uohm}) * 64'sd100) +
                     64'($signed(cfg_r.relax_res_tempco)) * 64'(dt_r);
          den_r   <= 32'((ts_r + {tc_r[19:0], 1'b0}) * 32'd100);
          cnt_r   <= cnt_r + 32'd1;
          if (csum > 65'sh0_7FFF_FFFF_FFFF_FFFF)      charge_r <= 64'sh7FFF_FFFF_FFFF_FFFF;
          else if (csum < -65'sh0_8000_0000_0000_0000) charge_r <= 64'sh8000_0000_0000_0000;
          else                                          charge_r <= csum[63:0];
          num_r   <= '0;
        end
        ST_MUL_A, ST_MUL_B, ST_MUL_C: if (mdone) num_r <= num_r + mprod;
        ST_MUL_D: neg_r <= num_r[127];
        ST_ROUND: begin
          x_r    <= xn;
          prev_r <= cur_r;
        end
        ST_OUT: begin
          o_voc_r   <= (voc > 50'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                       (voc < -50'sh8000_0000) ? 32'h8000_0000 : voc[31:0];
          o_chg_r   <= chg;
          o_cnt_r   <= cnt_r;
          o_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/core/boce_mul.sv]
`timescale 1ns / 1ps
// Shared signed 64x64 multiplier, one 32x32 partial product per cycle.
// Depends on boce_pkg.
module boce_mul import boce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  boce_mul_req_t       req,
  output logic                done,
  output logic signed [127:0] prod
);
  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic [127:0] acc_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] sh;

  always_comb begin
    pa = cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
    pb = cnt_r[0] ? ub_r[63:32] : ub_r[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    sh = {64'd0, pp} << (7'(cnt_r[1]) * 7'd32 + 7'(cnt_r[0]) * 7'd32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ua_r   <= req.a[63] ? 64'(-req.a) : req.a;
        ub_r   <= req.b[63] ? 64'(-req.b) : req.b;
        neg_r  <= req.a[63] ^ req.b[63];
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + sh;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign prod = neg_r ? -$signed(acc_r) : $signed(acc_r);
endmodule

[rtl/core/boce_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider of a 128-bit magnitude by a 32-bit divisor.
// Depends on boce_pkg.
module boce_div import boce_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [31:0]  den,
  output logic         done,
  output logic [127:0] quo,
  output logic [32:0]  rem
);
  logic [7:0]  cnt_r;
  logic        busy_r;
  logic [127:0] q_r;
  logic [32:0]  r_r;
  logic [32:0]  trial;

  assign trial = {r_r[31:0], q_r[127]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r    <= num;
        r_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (trial >= {1'b0, den}) begin
          r_r <= trial - {1'b0, den};
          q_r <= {q_r[126:0], 1'b1};
        end else begin
          r_r <= trial;
          q_r <= {q_r[126:0], 1'b0};
        end
        cnt_r <= cnt_r + 8'd1;
        if (cnt_r == 8'(NumBits - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = q_r;
  assign rem = r_r;
endmodule

[tb/sv/tb_battery_open_circuit_voltage_estimator_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the battery open-circuit voltage estimator unit.
// Depends on boce_pkg, boce_if and the unit itself, and through the unit on boce_mul and boce_div.
module tb_battery_open_circuit_voltage_estimator_unit;
  import boce_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // Channels: input beat {current, voltage, temperature},
  // result beat {open-circuit voltage, charge, sample count}.
  boce_if #(.Width(48))  in_ch (clk);
  boce_if #(.Width(128)) out_ch (clk);

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  battery_open_circuit_voltage_estimator_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  typedef struct packed {
    logic signed [31:0] voc_uv;
    logic signed [63:0] charge;
    logic [31:0]        count;
  } estimate_t;

  // Shadow copy of the registers and of the estimator state.
  longint unsigned  shadow_reg [7];
  longint           last_current;
  longint           charge_twice;
  longint           drop_nv;
  logic [31:0]      samples_seen;

  estimate_t        pending_estimates [$];
  int               mismatches = 0;
  int               beats_taken = 0;
  bit               hold_off_done = 0;

  function automatic longint sign_ext(longint unsigned v, int w);
    longint unsigned m;
    m = 64'd1 << (w - 1);
    v = v & ((m << 1) - 1);
    return longint'(v ^ m) - longint'(m);
  endfunction

  function automatic void shadow_reset();
    shadow_reg[REG_REF_TEMP]   = 29815;
    shadow_reg[REG_SERIES_RES] = 0;
    shadow_reg[REG_SERIES_TC]  = 0;
    shadow_reg[REG_RELAX_RES]  = 0;
    shadow_reg[REG_RELAX_TC]   = 0;
    shadow_reg[REG_TIME_CONST] = 1000;
    shadow_reg[REG_INTERVAL]   = 1000;
    last_current = 0;
    charge_twice = 0;
    drop_nv = 0;
    samples_seen = 0;
  endfunction

  // Advance the shadow estimator by one sample and return its result.
  function automatic estimate_t estimate_sample(logic [15:0] cur_raw, logic [15:0] volt,
                                                logic [15:0] temp);
    longint cur, dt, ts, tc, step, r0c, rinfc, xq, voc;
    logic signed [64:0]  acc_sum;
    logic signed [127:0] fa, fb, num;
    logic [127:0]        mag, quo, rem, dvs, cap;
    bit                  neg;
    estimate_t           e;
    cur = sign_ext(cur_raw, 16);
    dt = longint'(temp) - longint'(shadow_reg[REG_REF_TEMP]);
    ts = shadow_reg[REG_INTERVAL] != 0 ? longint'(shadow_reg[REG_INTERVAL]) : 1;
    tc = shadow_reg[REG_TIME_CONST] != 0 ? longint'(shadow_reg[REG_TIME_CONST]) : 1;
    samples_seen = samples_seen + 1;

    // Doubled trapezoidal charge, saturating at the 64-bit limits.
    step = ts * (cur + last_current);
    acc_sum = 65'(signed'(charge_twice)) + 65'(signed'(step));
    if (acc_sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) charge_twice = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (acc_sum < -65'sh0_8000_0000_0000_0000)
      charge_twice = 64'sh8000_0000_0000_0000;
    else charge_twice = acc_sum[63:0];

    // Compensated resistances in hundredths of a microohm.
    r0c = 100 * longint'(shadow_reg[REG_SERIES_RES]) +
          sign_ext(shadow_reg[REG_SERIES_TC], 31) * dt;
    rinfc = r0c + 100 * longint'(shadow_reg[REG_RELAX_RES]) +
            sign_ext(shadow_reg[REG_RELAX_TC], 31) * dt;

    fa = step; fb = rinfc; num = fa * fb;
    fa = 2 * tc * (cur - last_current); fb = r0c; num = num + fa * fb;
    fa = 100 * (2 * tc - ts); fb = drop_nv; num = num + fa * fb;

    // Round half away from zero, then clamp to the 48-bit filter range.
    neg = num[127];
    mag = neg ? -num : num;
    dvs = 100 * (ts + 2 * tc);
    quo = mag / dvs;
    rem = mag % dvs;
    if (2 * rem >= dvs) quo = quo + 1;
    cap = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (quo > cap) quo = cap;
    drop_nv = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    last_current = cur;

    xq = (drop_nv < 0 ? -drop_nv : drop_nv);
    xq = (xq + 500) / 1000;
    if (drop_nv < 0) xq = -xq;
    voc = longint'(volt) * 1000 + xq;
    if (voc > 64'sd2147483647) voc = 64'sd2147483647;
    if (voc < -64'sd2147483648) voc = -64'sd2147483648;

    e.voc_uv = voc[31:0];
    e.charge = charge_twice >>> 1;
    e.count = samples_seen;
    return e;
  endfunction

  // Register write: setup beat, then access beat held until pready.
  task automatic write_reg(boce_reg_t idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    shadow_reg[idx] = value;
    case (idx)
      REG_REF_TEMP:   shadow_reg[idx] = value & 32'hFFFF;
      REG_SERIES_RES,
      REG_RELAX_RES:  shadow_reg[idx] = value & 32'h3FFF_FFFF;
      REG_SERIES_TC,
      REG_RELAX_TC:   shadow_reg[idx] = value & 32'h7FFF_FFFF;
      default:        shadow_reg[idx] = value & 32'hF_FFFF;
    endcase
  endtask

  task automatic write_all(logic [31:0] tref, logic [31:0] r1, logic [31:0] r1t,
                           logic [31:0] r2, logic [31:0] r2t, logic [31:0] tc,
                           logic [31:0] ts);
    write_reg(REG_REF_TEMP, tref);
    write_reg(REG_SERIES_RES, r1);
    write_reg(REG_SERIES_TC, r1t);
    write_reg(REG_RELAX_RES, r2);
    write_reg(REG_RELAX_TC, r2t);
    write_reg(REG_TIME_CONST, tc);
    write_reg(REG_INTERVAL, ts);
  endtask

  // Drop valid, drain all pending estimates, then let the unit settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer one sample beat after a random gap; keep valid high across zero gaps.
  task automatic send_sample(logic [15:0] cur, logic [15:0] volt, logic [15:0] temp,
                             bit typed, estimate_t typed_est);
    int gap;
    estimate_t e;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {cur, volt, temp};
    do @(posedge clk); while (!in_ch.ready);
    e = estimate_sample(cur, volt, temp);
    if (typed) e = typed_est;
    pending_estimates.push_back(e);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_res();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 1000000000));
      1: return 32'($urandom_range(0, 100000));
      2: return 32'($urandom);
      default: return 32'($urandom_range(0, 5000));
    endcase
  endfunction

  function automatic logic [31:0] pick_tempco();
    case ($urandom_range(0, 3))
      0: return 32'(-int'($urandom_range(0, 1000000000)));
      1: return 32'($urandom_range(0, 1000000000));
      2: return 32'($urandom);
      default: return 32'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // Result side: random ready stalls, one long hold-off to back up the input.
  initial begin
    int n;
    estimate_t got, want;
    @(posedge rst_n);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        beats_taken++;
        if (pending_estimates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = pending_estimates.pop_front();
          if (got.voc_uv !== want.voc_uv || got.charge !== want.charge ||
              got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected voc %0d chg %0d cnt %0d, got %0d %0d %0d",
                       beats_taken, want.voc_uv, want.charge, want.count,
                       got.voc_uv, got.charge, got.count);
          end
        end
        n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        if (!hold_off_done && beats_taken == 300) begin
          hold_off_done = 1;
          n = 800;
        end
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n - 1) @(posedge clk);
          @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #40ms;
    $display("battery_open_circuit_voltage_estimator_unit verification failed");
    $finish;
  end

  typedef struct {
    logic [15:0] cur, volt, temp;
    bit          typed;
    estimate_t   est;
  } sample_row_t;

  sample_row_t directed [] = '{
    // After reset with zero resistance: plain voltage scaling and charge.
    '{16'h0000, 16'h0000, 16'd29815, 1, '{32'sd0, 64'sd0, 32'd1}},
    '{16'h7FFF, 16'hFFFF, 16'd29815, 1, '{32'sd65535000, 64'sd16383500, 32'd2}},
    '{16'h8000, 16'h0000, 16'hFFFF, 0, '0},
    '{16'h8000, 16'hFFFF, 16'h0000, 0, '0},
    '{16'h0001, 16'h1234, 16'd30000, 0, '0}
  };

  initial begin
    int k, sets;
    estimate_t none;
    none = '0;
    shadow_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under reset settings.
    foreach (directed[i])
      send_sample(directed[i].cur, directed[i].volt, directed[i].temp,
                  directed[i].typed, directed[i].est);
    drain();

    // Extreme resistances, shortest times: drives voltage saturation.
    write_all(25000, 1000000000, 1000000000, 1000000000, 1000000000, 1, 1);
    send_sample(16'h7FFF, 16'hFFFF, 16'hFFFF, 0, none);
    send_sample(16'h8000, 16'h0000, 16'h0000, 0, none);
    send_sample(16'h8000, 16'h0000, 16'hFFFF, 0, none);
    send_sample(16'h7FFF, 16'hFFFF, 16'h0000, 0, none);
    drain();
    // Zero time values read as one; sample interval equal to the time constant.
    write_all(35000, 1000, 32'hC465_3600, 500, 32'hFFFF_FF00, 0, 0);
    send_sample(16'h7FFF, 16'h1000, 16'h0000, 0, none);
    send_sample(16'h8000, 16'h2000, 16'hFFFF, 0, none);
    drain();
    write_all(29815, 20000, 32'hFFFF_FFF6, 30000, 5, 10, 1000000);
    send_sample(16'h7FFF, 16'h0F00, 16'd29815, 0, none);
    send_sample(16'h8000, 16'h0F00, 16'd10000, 0, none);
    drain();
    // Times of 1000000 ms each, all-ones register bits.
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF,
              1000000, 1000000);
    send_sample(16'h7FFF, 16'hFFFF, 16'h0000, 0, none);
    send_sample(16'h8000, 16'h0000, 16'hFFFF, 0, none);
    drain();

    // Random settings, random samples, temperature mostly near reference.
    for (sets = 0; sets < 6; sets++) begin
      write_all($urandom_range(25000, 35000), pick_res(), pick_tempco(), pick_res(),
                pick_tempco(), $urandom_range(0, 3) == 0 ? 32'($urandom) :
                32'($urandom_range(1, 1000000)), $urandom_range(0, 3) == 0 ?
                32'($urandom) : 32'($urandom_range(1, 5000)));
      for (k = 0; k < 250; k++)
        send_sample(pick16(), pick16(), $urandom_range(0, 3) == 0 ? pick16() :
                    16'($urandom_range(25000, 35000)), 0, none);
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_estimates.size() == 0)
      $display("battery_open_circuit_voltage_estimator_unit verification clean");
    else
      $display("battery_open_circuit_voltage_estimator_unit verification failed");
    $finish;
  end

endmodule
